[hw/rtl/smf_pkg.sv]
// Package for the sliding window median filter.
// Holds the window length, the sample type and the rank constants.
// No dependencies.
package smf_pkg;

    // Number of samples held in the sliding window (3 to 31).
    localparam int WINDOW = 19;

    // Width of one sample word.
    localparam int SAMPLE_W = 16;

    // Width of a rank value: ranks run from 0 to WINDOW-1.
    localparam int RANK_W = $clog2(WINDOW);

    // Rank of the median in the ascending order of the window.
    localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(WINDOW / 2);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t window_t [WINDOW];
    typedef logic [WINDOW-1:0] row_t;

endpackage

[hw/rtl/sliding_median_filter_top.sv]
// Sliding window median filter, top level.
// Depends on smf_pkg for the window length, rank constants and types.
//
// Usage:
// One signed 16-bit sample word enters on the sample channel and is accepted
// at a rising edge where sample_valid is high and sample_stall is low. The
// sample is shifted into a window of the WINDOW most recent samples and the
// oldest sample drops out. One median word leaves on the median channel for
// every accepted sample, in order; it is taken at an edge where median_valid
// is high and median_stall is low.
// An accepted word passes the window register, a registered comparison
// matrix and the median register, which form a three-stage pipeline; the
// rank count and median select between the last two stages set the cycle
// time. The filter takes one word per cycle while median_stall is low.
// Stages advance independently, so empty stages are filled while a median
// waits. When the receiver stalls and all three stages are full,
// sample_stall rises in the same cycle; it never depends on sample_valid.
// Reset clears the window to zeros and empties the pipeline. Until WINDOW
// samples have arrived, those zeros take part in the median. Equal samples
// are ranked by their window position, so the result matches a stable sort.
module sliding_median_filter_top
    import smf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  sample_t sample,
    output logic    median_valid,
    input  logic    median_stall,
    output sample_t median
);

    // Stage 1: the window itself, valid after an accepted word.
    window_t window_reg;
    logic    win_valid_reg;

    // Stage 2: a copy of the window and its comparison matrix.
    window_t cmp_win_reg;
    row_t    cmp_row_reg [WINDOW];
    row_t    cmp_row_next [WINDOW];
    logic    cmp_valid_reg;

    // Stage 3: the median word.
    sample_t median_reg;
    sample_t median_next;
    logic    median_valid_reg;

    logic ready_win;
    logic ready_cmp;
    logic ready_out;
    logic accept;
    row_t rank_match;

    // Each stage can load when it is empty or its word moves on this cycle.
    assign ready_out    = !median_valid_reg || !median_stall;
    assign ready_cmp    = !cmp_valid_reg || ready_out;
    assign ready_win    = !win_valid_reg || ready_cmp;
    assign sample_stall = !ready_win;
    assign accept       = sample_valid && ready_win;

    assign median_valid = median_valid_reg;
    assign median       = median_reg;

    // Valid flags of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg    <= 1'b0;
            cmp_valid_reg    <= 1'b0;
            median_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_win)
            begin
                win_valid_reg <= sample_valid;
            end
            if (ready_cmp)
            begin
                cmp_valid_reg <= win_valid_reg;
            end
            if (ready_out)
            begin
                median_valid_reg <= cmp_valid_reg;
            end
        end
    end

    // Shift the accepted word into the window; the oldest entry drops out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            window_reg[0] <= sample;
            for (int i = 1; i < WINDOW; i++)
            begin
                window_reg[i] <= window_reg[i-1];
            end
        end
    end

    // Row i marks every entry that sorts ahead of entry i; ties go by position.
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            for (int j = 0; j < WINDOW; j++)
            begin
                cmp_row_next[i][j] = (window_reg[j] < window_reg[i]) ||
                                     ((window_reg[j] == window_reg[i]) && (j < i));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_cmp && win_valid_reg)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                cmp_win_reg[i] <= window_reg[i];
                cmp_row_reg[i] <= cmp_row_next[i];
            end
        end
    end

    // Count each row to get its rank and pick the entry of median rank.
    always_comb
    begin
        median_next = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            rank_match[i] = (RANK_W'($countones(cmp_row_reg[i])) == MID_RANK);
            if (rank_match[i])
            begin
                median_next = median_next | cmp_win_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && cmp_valid_reg)
        begin
            median_reg <= median_next;
        end
    end

    // Stable ranking is a permutation, so exactly one entry has median rank.
    a_one_median: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> $onehot(rank_match))
        else $error("median rank not held by exactly one window entry");

    // The input stalls only while every stage holds a word.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (win_valid_reg && cmp_valid_reg && median_valid_reg))
        else $error("input stalled with an empty stage");

    // An accepted word becomes the newest window entry.
    a_window_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (window_reg[0] == $past(sample)))
        else $error("accepted word missing from window head");

    // A waiting median holds its value.
    a_median_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (median_valid && median_stall) |=> (median_valid && $stable(median)))
        else $error("stalled median word changed");

endmodule
